>>> sv/sdcs_pkg.sv
package sdcs_pkg;

  localparam int RAW_W           = 16;
  localparam int OUT_W           = 8;
  localparam int REG_W           = 15;
  localparam int DIV_W           = 16;
  localparam int Q_MAX           = 127;
  localparam int CAL_SAMPLES_DEF = 256;

  localparam logic [REG_W-1:0] CPI_RST = REG_W'(1024);
  localparam logic [REG_W-1:0] LIM_RST = REG_W'(8);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CPI = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIM = 1'b1;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_NUDGE,
    OP_SCALE,
    OP_CAL
  } lane_op_t;

  typedef struct packed {
    lane_op_t op;
    logic     last;
  } lane_cmd_t;

  typedef struct packed {
    logic                    in_win;
    logic                    done;
    logic                    nz;
    logic signed [OUT_W-1:0] q;
  } lane_stat_t;

endpackage

>>> sv/sdcs_in_if.sv
interface sdcs_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  mode;
  logic signed [sdcs_pkg::RAW_W-1:0]     raw_x;
  logic signed [sdcs_pkg::RAW_W-1:0]     raw_y;

  modport source (output valid, mode, raw_x, raw_y, input ready);
  modport sink (input valid, mode, raw_x, raw_y, output ready);
endinterface

>>> sv/sdcs_out_if.sv
interface sdcs_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sdcs_pkg::OUT_W-1:0]     dx;
  logic signed [sdcs_pkg::OUT_W-1:0]     dy;
  logic                                  moved;
  logic                                  neutral;

  modport source (output valid, dx, dy, moved, neutral, input ready);
  modport sink (input valid, dx, dy, moved, neutral, output ready);
endinterface

>>> sv/sdcs_lane.sv
module sdcs_lane #(
  parameter int CAL_SAMPLES = sdcs_pkg::CAL_SAMPLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sdcs_pkg::lane_cmd_t                 cmd,
  input  logic signed [sdcs_pkg::RAW_W-1:0]   raw,
  input  logic [sdcs_pkg::REG_W-1:0]          cpi,
  input  logic [sdcs_pkg::REG_W-1:0]          lim,
  output sdcs_pkg::lane_stat_t                stat
);

  localparam int RAW_W = sdcs_pkg::RAW_W;
  localparam int DIV_W = sdcs_pkg::DIV_W;
  localparam int OUT_W = sdcs_pkg::OUT_W;
  localparam int SUM_W = RAW_W + $clog2(CAL_SAMPLES);
  localparam int CNT_W = $clog2(SUM_W + 1);
  localparam int WIN_W = RAW_W + 2;
  localparam logic [DIV_W-1:0] CAL_DIVISOR = DIV_W'(CAL_SAMPLES);
  localparam logic [CNT_W-1:0] LAST_STEP   = CNT_W'(SUM_W - 1);

  logic signed [RAW_W-1:0] zero_r, drift_r, rem_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0]        dvd_r;
  logic [DIV_W:0]          prem_r;
  logic [DIV_W-1:0]        dvs_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    busy_r, fin_r, neg_r, tcal_r, done_r, nz_r;
  logic signed [OUT_W-1:0] q_r;

  logic signed [WIN_W-1:0] raw_w, zero_w, drift_w, lim_w, d1, d_nudge;
  logic                    in_win, up;
  logic signed [SUM_W-1:0] v, sum_nxt, dvd_start;
  logic [SUM_W-1:0]        dvd_mag;
  logic [DIV_W-1:0]        cpi_eff;
  logic [DIV_W:0]          shifted, diff;
  logic                    qbit;
  logic [SUM_W-1:0]        q_sgn;
  logic [DIV_W-1:0]        r_sgn;
  logic [OUT_W-2:0]        q_sat;
  logic signed [OUT_W-1:0] q_fin;

  always_comb begin
    raw_w   = WIN_W'(raw);
    zero_w  = WIN_W'(zero_r);
    drift_w = WIN_W'(drift_r);
    lim_w   = $signed({{(WIN_W-sdcs_pkg::REG_W){1'b0}}, lim});
    in_win  = (raw_w < zero_w + lim_w) && (raw_w > zero_w - lim_w);
    up      = raw_w > zero_w + drift_w;
    d1      = up ? drift_w + WIN_W'(1) : drift_w - WIN_W'(1);
    if (d1 > lim_w) begin
      d_nudge = lim_w;
    end else if (d1 < -lim_w) begin
      d_nudge = -lim_w;
    end else begin
      d_nudge = d1;
    end

    v         = SUM_W'(raw) - SUM_W'(zero_r) - SUM_W'(drift_r) + SUM_W'(rem_r);
    sum_nxt   = sum_r + SUM_W'(raw);
    dvd_start = (cmd.op == sdcs_pkg::OP_SCALE) ? v : sum_nxt;
    dvd_mag   = dvd_start[SUM_W-1] ? SUM_W'(-dvd_start) : SUM_W'(dvd_start);
    cpi_eff   = (cpi == '0) ? DIV_W'(1) : DIV_W'(cpi);

    shifted = {prem_r[DIV_W-1:0], dvd_r[SUM_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    qbit    = !diff[DIV_W];

    q_sgn = neg_r ? SUM_W'(-dvd_r) : dvd_r;
    r_sgn = neg_r ? DIV_W'(-prem_r[DIV_W-1:0]) : prem_r[DIV_W-1:0];
    q_sat = (dvd_r > SUM_W'(sdcs_pkg::Q_MAX)) ? (OUT_W-1)'(sdcs_pkg::Q_MAX)
                                              : dvd_r[OUT_W-2:0];
    q_fin = neg_r ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_r  <= '0;
      drift_r <= '0;
      rem_r   <= '0;
      sum_r   <= '0;
      busy_r  <= 1'b0;
      fin_r   <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      fin_r  <= 1'b0;
      unique case (cmd.op)
        sdcs_pkg::OP_NONE: begin
        end
        sdcs_pkg::OP_NUDGE: begin
          drift_r <= d_nudge[RAW_W-1:0];
        end
        sdcs_pkg::OP_SCALE: begin
          dvd_r  <= dvd_mag;
          neg_r  <= dvd_start[SUM_W-1];
          prem_r <= '0;
          dvs_r  <= cpi_eff;
          tcal_r <= 1'b0;
          cnt_r  <= '0;
          busy_r <= 1'b1;
        end
        sdcs_pkg::OP_CAL: begin
          if (cmd.last) begin
            sum_r  <= '0;
            dvd_r  <= dvd_mag;
            neg_r  <= dvd_start[SUM_W-1];
            prem_r <= '0;
            dvs_r  <= CAL_DIVISOR;
            tcal_r <= 1'b1;
            cnt_r  <= '0;
            busy_r <= 1'b1;
          end else begin
            sum_r <= sum_nxt;
          end
        end
      endcase
      if (busy_r) begin
        prem_r <= qbit ? diff : shifted;
        dvd_r  <= {dvd_r[SUM_W-2:0], qbit};
        cnt_r  <= cnt_r + CNT_W'(1);
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
      if (fin_r) begin
        if (tcal_r) begin
          zero_r <= q_sgn[RAW_W-1:0];
        end else begin
          rem_r <= r_sgn[RAW_W-1:0];
        end
        q_r    <= q_fin;
        nz_r   <= dvd_r != '0;
        done_r <= 1'b1;
      end
    end
  end

  assign stat.in_win = in_win;
  assign stat.done   = done_r;
  assign stat.nz     = nz_r;
  assign stat.q      = q_r;

endmodule

>>> sv/stick_drift_comp_scaler_unit.sv
// Pointing-stick scaler: one word in gives one word out. A tracking word that
// falls in the neutral window, or a calibration word that does not close a
// round, skips the wait state; a scaled tracking word, or the calibration word
// that closes a round, waits in that state on the one-bit-per-cycle restoring
// divider in each of the two axis lanes. The X and Y lanes run side by side and
// the result is merged into an output register, so a new word is taken while
// the last result still waits. Configuration writes land at once and belong in
// idle periods.
module stick_drift_comp_scaler_unit #(
  parameter int CAL_SAMPLES = sdcs_pkg::CAL_SAMPLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  sdcs_in_if.sink                             in_if,
  sdcs_out_if.source                          out_if,
  input  logic                                cfg_we,
  input  logic [sdcs_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [sdcs_pkg::REG_W-1:0]          cfg_wdata
);

  localparam int RAW_W = sdcs_pkg::RAW_W;
  localparam int OUT_W = sdcs_pkg::OUT_W;
  localparam int CC_W  = $clog2(CAL_SAMPLES);
  localparam logic [CC_W-1:0] CC_LAST = CC_W'(CAL_SAMPLES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_WAIT,
    S_DONE
  } state_t;

  state_t                      state_r;
  logic [sdcs_pkg::REG_W-1:0]  cpi_r, lim_r;
  logic                        mode_r;
  logic signed [RAW_W-1:0]     raw_x_r, raw_y_r;
  logic [CC_W-1:0]             cal_cnt_r;
  logic signed [OUT_W-1:0]     res_dx_r, res_dy_r;
  logic                        res_moved_r, res_neutral_r;
  logic                        out_valid_r;
  logic signed [OUT_W-1:0]     out_dx_r, out_dy_r;
  logic                        out_moved_r, out_neutral_r;

  sdcs_pkg::lane_cmd_t  cmd;
  sdcs_pkg::lane_stat_t lx_st, ly_st;
  logic                 both_win, cal_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpi_r <= sdcs_pkg::CPI_RST;
      lim_r <= sdcs_pkg::LIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        sdcs_pkg::CFG_CPI: cpi_r <= cfg_wdata;
        sdcs_pkg::CFG_LIM: lim_r <= cfg_wdata;
      endcase
    end
  end

  assign both_win = lx_st.in_win && ly_st.in_win;
  assign cal_last = cal_cnt_r == CC_LAST;

  always_comb begin
    cmd.op   = sdcs_pkg::OP_NONE;
    cmd.last = 1'b0;
    if (state_r == S_EVAL) begin
      if (mode_r) begin
        cmd.op   = sdcs_pkg::OP_CAL;
        cmd.last = cal_last;
      end else if (both_win) begin
        cmd.op = sdcs_pkg::OP_NUDGE;
      end else begin
        cmd.op = sdcs_pkg::OP_SCALE;
      end
    end
  end

  sdcs_lane #(.CAL_SAMPLES(CAL_SAMPLES)) u_lane_x (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .raw   (raw_x_r),
    .cpi   (cpi_r),
    .lim   (lim_r),
    .stat  (lx_st)
  );

  sdcs_lane #(.CAL_SAMPLES(CAL_SAMPLES)) u_lane_y (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .raw   (raw_y_r),
    .cpi   (cpi_r),
    .lim   (lim_r),
    .stat  (ly_st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cal_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_if.valid) begin
            mode_r  <= in_if.mode;
            raw_x_r <= in_if.raw_x;
            raw_y_r <= in_if.raw_y;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          res_dx_r      <= '0;
          res_dy_r      <= '0;
          res_moved_r   <= 1'b0;
          res_neutral_r <= 1'b0;
          if (mode_r) begin
            cal_cnt_r <= cal_last ? '0 : cal_cnt_r + CC_W'(1);
            state_r   <= cal_last ? S_WAIT : S_DONE;
          end else if (both_win) begin
            res_neutral_r <= 1'b1;
            state_r       <= S_DONE;
          end else begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (lx_st.done) begin
            if (!mode_r) begin
              res_dx_r    <= lx_st.q;
              res_dy_r    <= ly_st.q;
              res_moved_r <= lx_st.nz || ly_st.nz;
            end
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_r   <= 1'b1;
            out_dx_r      <= res_dx_r;
            out_dy_r      <= res_dy_r;
            out_moved_r   <= res_moved_r;
            out_neutral_r <= res_neutral_r;
            state_r       <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_if.ready    = state_r == S_IDLE;
  assign out_if.valid   = out_valid_r;
  assign out_if.dx      = out_dx_r;
  assign out_if.dy      = out_dy_r;
  assign out_if.moved   = out_moved_r;
  assign out_if.neutral = out_neutral_r;

  a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    lx_st.done == ly_st.done)
    else $error("axis lanes finished out of step");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("second word taken while one is in flight");

  a_neutral_still: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_neutral_r |-> !out_moved_r && out_dx_r == '0 && out_dy_r == '0)
    else $error("neutral word reports motion");

  a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    lx_st.done |-> state_r == S_WAIT)
    else $error("divider result arrived outside wait");

  a_cal_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cal_cnt_r <= CC_LAST)
    else $error("calibration count past round length");

endmodule
